@@ rtl/nsr_pkg.sv @@
// Shared types and character codes for the number syntax recognizer.
// No dependencies; imported by every module of the block.
package nsr_pkg;

   localparam int unsigned CHAR_W = 8;
   localparam int unsigned RSP_W  = 8;

   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_EXP_U = 8'h45;
   localparam logic [CHAR_W-1:0] CHAR_EXP_L = 8'h65;

   // Decoded character class; at most one bit set, none for other bytes.
   typedef struct packed {
      logic digit;
      logic sign;
      logic dot;
      logic expo;
   } char_class_type;

   // One decoded character waiting in the input register.
   typedef struct packed {
      logic           valid;
      logic           last;
      char_class_type cls;
   } stage_type;

   function automatic char_class_type classify(input logic [CHAR_W-1:0] c);
      char_class_type r;
      r.digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      r.sign  = (c == CHAR_PLUS) || (c == CHAR_MINUS);
      r.dot   = (c == CHAR_DOT);
      r.expo  = (c == CHAR_EXP_U) || (c == CHAR_EXP_L);
      return r;
   endfunction

endpackage

@@ rtl/nsr_input_stage.sv @@
// Input register of the number syntax recognizer: decodes the incoming
// character into class flags and holds it until the core consumes it.
// Depends on nsr_pkg.
module nsr_input_stage (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   input  logic [nsr_pkg::CHAR_W-1:0] char_code,
   input  logic                      req_tlast,
   input  logic                      take,      // core consumes the held character
   output logic                      ready,
   output nsr_pkg::stage_type        stage
);
   import nsr_pkg::*;

   logic           valid_ff, valid_in;
   logic           last_ff;
   char_class_type cls_ff;
   logic           load;

   assign ready = !valid_ff || take;
   assign load  = req_tvalid && ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         last_ff <= req_tlast;
         cls_ff  <= classify(char_code);
      end
   end

   assign stage.valid = valid_ff;
   assign stage.last  = last_ff;
   assign stage.cls   = cls_ff;

endmodule

@@ rtl/nsr_syntax_core.sv @@
// Word-level syntax state and result register of the number syntax
// recognizer. Depends on nsr_pkg.
module nsr_syntax_core (
   input  logic               clock,
   input  logic               reset,
   input  nsr_pkg::stage_type stage,
   input  logic               rsp_tready,
   output logic               take,
   output logic               rsp_tvalid,
   output logic               is_number,
   output logic               is_integer
);
   import nsr_pkg::*;

   logic first_ff, rej_ff, dot_ff, idot_ff, exp_ff, smf_ff, lone_ff;
   logic first_in, rej_in, dot_in, idot_in, exp_in, smf_in, lone_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic num_ff, int_ff;
   logic out_free;
   char_class_type c;

   assign c        = stage.cls;
   assign out_free = !rsp_valid_ff || rsp_tready;
   // A non-final character needs no result slot.
   assign take     = stage.valid && (!stage.last || out_free);

   always_comb begin
      rej_in   = rej_ff;
      dot_in   = dot_ff;
      idot_in  = idot_ff;
      exp_in   = exp_ff;
      smf_in   = smf_ff;
      lone_in  = lone_ff;
      first_in = 1'b0;
      if (first_ff) begin
         if (!(c.sign || c.digit || c.dot)) begin
            rej_in = 1'b1;
         end
         lone_in = c.sign || c.dot;
         if (c.dot) begin
            dot_in = 1'b1;
         end
         if (c.expo) begin
            exp_in = 1'b1;
         end
      end else begin
         smf_in  = 1'b0;
         lone_in = 1'b0;
         if (smf_ff && c.sign) begin
            rej_in = rej_ff;  // exponent sign
         end else if (c.expo) begin
            if (idot_ff || exp_ff) begin
               rej_in = 1'b1;
            end
            exp_in = 1'b1;
            smf_in = 1'b1;
         end else if (c.dot) begin
            if (dot_ff || exp_ff) begin
               rej_in = 1'b1;
            end
            dot_in  = 1'b1;
            idot_in = 1'b1;
         end else if (!c.digit) begin
            rej_in = 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (take && stage.last) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff     <= 1'b1;
         rej_ff       <= 1'b0;
         dot_ff       <= 1'b0;
         idot_ff      <= 1'b0;
         exp_ff       <= 1'b0;
         smf_ff       <= 1'b0;
         lone_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            if (stage.last) begin
               first_ff <= 1'b1;
               rej_ff   <= 1'b0;
               dot_ff   <= 1'b0;
               idot_ff  <= 1'b0;
               exp_ff   <= 1'b0;
               smf_ff   <= 1'b0;
               lone_ff  <= 1'b0;
            end else begin
               first_ff <= first_in;
               rej_ff   <= rej_in;
               dot_ff   <= dot_in;
               idot_ff  <= idot_in;
               exp_ff   <= exp_in;
               smf_ff   <= smf_in;
               lone_ff  <= lone_in;
            end
         end
      end
      if (take && stage.last) begin
         num_ff <= !rej_in && !lone_in;
         int_ff <= !dot_in && !exp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign is_number  = num_ff;
   assign is_integer = int_ff;

endmodule

@@ rtl/number_syntax_recognizer.sv @@
// Number syntax recognizer, top level: input register plus syntax core.
// Depends on nsr_pkg, nsr_input_stage and nsr_syntax_core.
//
// Checks whether a word, sent one character per transaction with tlast on
// its final character, is a number: an optional leading sign or dot, then
// digits, dots and e/E, with a sign allowed only right after an exponent
// letter. One result transaction comes out for each word, after its last
// character: bit 0 says the word is a valid number, bit 1 that it holds no
// dot, e or E. Non-final characters produce nothing. Throughput is one
// character per clock while the result side does not stall; the last
// character passes the input register, then the result register. The
// result register frees as it is taken, so a stall on the result side
// holds back the input only when a new result is due and the old one is
// still waiting.
module number_syntax_recognizer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_code
   input  logic       req_tlast,   // is_last
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [0] is_number, [1] is_integer, [7:2] zero
);
   import nsr_pkg::*;

   stage_type stage;
   logic      take;
   logic      is_number;
   logic      is_integer;

   nsr_input_stage u_input (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .char_code  (req_tdata[CHAR_W-1:0]),
      .req_tlast  (req_tlast),
      .take       (take),
      .ready      (req_tready),
      .stage      (stage)
   );

   nsr_syntax_core u_core (
      .clock      (clock),
      .reset      (reset),
      .stage      (stage),
      .rsp_tready (rsp_tready),
      .take       (take),
      .rsp_tvalid (rsp_tvalid),
      .is_number  (is_number),
      .is_integer (is_integer)
   );

   assign rsp_tdata = {{(RSP_W-2){1'b0}}, is_integer, is_number};

endmodule

@@ tb/sv/number_syntax_recognizer_tb.sv @@
// Self-checking testbench for number_syntax_recognizer: streams words one character at a time,
// predicts each word's verdict and checks every result transaction against it.
// Depends on nsr_pkg and the number_syntax_recognizer RTL.
module number_syntax_recognizer_tb;
   import nsr_pkg::*;

   // One character transaction waiting to go out on the request side.
   typedef struct {
      logic [7:0] code;
      logic       last;
   } char_item_type;

   // Expected verdict for one word, in result tdata bit order.
   typedef struct packed {
      logic is_integer;
      logic is_number;
   } verdict_type;

   // Receiver behavior, switched in turn by the top two bits of stall_cycle.
   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_RANDOM,
      READY_PERIODIC,
      READY_SPARSE
   } ready_mode_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;
   logic       req_tlast = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;

   char_item_type pending_chars[$];
   logic [7:0]    word_buf[$];
   verdict_type   expected_verdicts[$];

   int chars_total = 0;
   int chars_accepted = 0;
   int mismatches = 0;

   // Driver pacing.
   logic req_fire = 1'b0;
   int   burst_left = 0;
   int   gap_left = 0;
   logic [8:0] stall_cycle = '0;

   // Word state of the predictor, at its between-words values.
   bit first_pos = 1'b1;
   bit broken = 1'b0;
   bit any_dot = 1'b0;
   bit later_dot = 1'b0;
   bit exp_seen = 1'b0;
   bit exp_just_seen = 1'b0;
   bit only_prefix = 1'b0;

   number_syntax_recognizer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [7:0] char_code
      .req_tlast  (req_tlast),   // is_last
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)    // [0] is_number, [1] is_integer, [7:2] zero
   );

   always #2 clock = ~clock;

   // Advance the word state by one accepted character; on the last
   // character of a word, queue its verdict and clear the state.
   task automatic judge_char(input logic [7:0] c, input logic last);
      logic digit, sign, dot, expo, after_exp;
      digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      sign  = (c == CHAR_PLUS) || (c == CHAR_MINUS);
      dot   = (c == CHAR_DOT);
      expo  = (c == CHAR_EXP_U) || (c == CHAR_EXP_L);
      if (first_pos) begin
         if (!(sign || digit || dot))
            broken = 1'b1;
         only_prefix = sign || dot;
         if (dot)
            any_dot = 1'b1;
         // an exponent letter up front is already rejected, but still
         // makes the word non-integer
         if (expo)
            exp_seen = 1'b1;
         first_pos = 1'b0;
      end else begin
         after_exp = exp_just_seen;
         exp_just_seen = 1'b0;
         only_prefix = 1'b0;
         // a sign right after e/E is the exponent's sign and always passes
         if (!(after_exp && sign)) begin
            if (expo) begin
               if (later_dot || exp_seen)
                  broken = 1'b1;
               exp_seen = 1'b1;
               exp_just_seen = 1'b1;
            end else if (dot) begin
               if (any_dot || exp_seen)
                  broken = 1'b1;
               any_dot = 1'b1;
               later_dot = 1'b1;
            end else if (!digit) begin
               broken = 1'b1;
            end
         end
      end
      if (last) begin
         expected_verdicts.push_back('{is_integer: !any_dot && !exp_seen,
                                       is_number: !broken && !only_prefix});
         first_pos = 1'b1;
         broken = 1'b0;
         any_dot = 1'b0;
         later_dot = 1'b0;
         exp_seen = 1'b0;
         exp_just_seen = 1'b0;
         only_prefix = 1'b0;
      end
   endtask

   // Random character, biased toward the ones the syntax cares about.
   function automatic logic [7:0] pick_char();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 3)
         return CHAR_ZERO + 8'($urandom_range(0, 9));
      else if (roll < 5)
         return $urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS;
      else if (roll < 6)
         return CHAR_DOT;
      else if (roll < 7)
         return $urandom_range(0, 1) ? CHAR_EXP_U : CHAR_EXP_L;
      else
         return 8'($urandom_range(1, 255));
   endfunction

   // Move word_buf into the request queue, tlast on its final character.
   task automatic queue_word();
      int i;
      for (i = 0; i < word_buf.size(); i++)
         pending_chars.push_back('{code: word_buf[i], last: (i == word_buf.size() - 1)});
      word_buf.delete();
   endtask

   task automatic queue_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++)
         word_buf.push_back(s[i]);
      queue_word();
   endtask

   // Mostly well-formed numbers with random content, some with one character
   // swapped out, the rest plain noise.
   task automatic make_word();
      int shape;
      shape = $urandom_range(0, 9);
      if (shape < 7) begin
         case ($urandom_range(0, 3))
            0: word_buf.push_back($urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS);
            1: word_buf.push_back(CHAR_DOT);
            default: ;
         endcase
         repeat ($urandom_range(0, 4))
            word_buf.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
         if ($urandom_range(0, 2) == 0) begin
            word_buf.push_back(CHAR_DOT);
            repeat ($urandom_range(0, 3))
               word_buf.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
         end
         if ($urandom_range(0, 2) == 0) begin
            word_buf.push_back($urandom_range(0, 1) ? CHAR_EXP_U : CHAR_EXP_L);
            if ($urandom_range(0, 1))
               word_buf.push_back($urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS);
            repeat ($urandom_range(0, 3))
               word_buf.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
         end
         if (word_buf.size() == 0)
            word_buf.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
         if (shape == 6)
            word_buf[$urandom_range(0, word_buf.size() - 1)] = pick_char();
      end else begin
         repeat ($urandom_range(1, 6))
            word_buf.push_back(pick_char());
      end
      queue_word();
   endtask

   // Sender: bursts of random length, random gaps between them (zero-length
   // gaps give unbroken stretches). An offered transaction is held until taken.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_fire) begin
         // still waiting on tready
      end else if (gap_left > 0) begin
         gap_left <= gap_left - 1;
         req_tvalid <= 1'b0;
      end else if (pending_chars.size() > 0) begin
         req_tvalid <= 1'b1;
         req_tdata <= pending_chars[0].code;
         req_tlast <= pending_chars[0].last;
         pending_chars.pop_front();
         if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 24);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         end else begin
            burst_left <= burst_left - 1;
         end
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // Receiver: cycles through always-ready, coin-flip, periodic and
   // long-stall stretches.
   always @(negedge clock) begin
      stall_cycle <= stall_cycle + 9'd1;
      case (ready_mode_type'(stall_cycle[8:7]))
         READY_ALWAYS:   rsp_tready <= 1'b1;
         READY_RANDOM:   rsp_tready <= 1'($urandom_range(0, 1));
         READY_PERIODIC: rsp_tready <= (stall_cycle[1:0] != 2'b00);
         READY_SPARSE:   rsp_tready <= (stall_cycle[4:0] < 5'd4);
         default:        rsp_tready <= 1'b1;
      endcase
   end

   // Monitor: result check first, then prediction for the character taken
   // at this edge (its result cannot appear before a later edge).
   always @(posedge clock) begin
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) begin
            if (expected_verdicts.size() == 0) begin
               $display("%0t: result with no word pending, expected none actual %b",
                        $time, rsp_tdata);
               mismatches++;
            end else begin
               if (rsp_tdata[0] !== expected_verdicts[0].is_number) begin
                  $display("%0t: is_number mismatch, expected %b actual %b",
                           $time, expected_verdicts[0].is_number, rsp_tdata[0]);
                  mismatches++;
               end
               if (rsp_tdata[1] !== expected_verdicts[0].is_integer) begin
                  $display("%0t: is_integer mismatch, expected %b actual %b",
                           $time, expected_verdicts[0].is_integer, rsp_tdata[1]);
                  mismatches++;
               end
               if (rsp_tdata[7:2] !== 6'b0) begin
                  $display("%0t: padding mismatch, expected %b actual %b",
                           $time, 6'b0, rsp_tdata[7:2]);
                  mismatches++;
               end
               expected_verdicts.pop_front();
            end
         end
         if (req_tvalid && req_tready) begin
            judge_char(req_tdata, req_tlast);
            chars_accepted++;
         end
      end
   end

   initial begin
      int directed_chars;
      // Directed words: lone prefixes, signs before an exponent, trailing
      // exponents, NUL and top byte, upper-case exponent, dot then exponent.
      queue_text("+");
      queue_text(".");
      queue_text("+e");
      queue_text("-.e");
      queue_text("1e");
      queue_text("1e+");
      word_buf.push_back(CHAR_ZERO + 8'd1);
      word_buf.push_back(8'h00);
      queue_word();
      word_buf.push_back(8'hFF);
      queue_word();
      queue_text("0.5E-7");
      queue_text("1.e");
      directed_chars = pending_chars.size();
      while (pending_chars.size() < directed_chars + 600)
         make_word();
      chars_total = pending_chars.size();

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (chars_accepted == chars_total);
      wait (expected_verdicts.size() == 0);
      // leave room for a stray extra result
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("PASS number_syntax_recognizer");
      else
         $display("FAIL number_syntax_recognizer");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #2000000;
      $display("FAIL number_syntax_recognizer");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/nsr_pkg.sv
rtl/nsr_input_stage.sv
rtl/nsr_syntax_core.sv
rtl/number_syntax_recognizer.sv
tb/sv/number_syntax_recognizer_tb.sv
